[hdl/tsbq_pkg.sv]
// ----------------------------------------------------------------------------
// tsbq_pkg
// shared types, codes and defaults for the typed shared buffer queue
// ----------------------------------------------------------------------------
package tsbq_pkg;

   localparam int DEPTH_DEF      = 32;
   localparam int CLASSES_DEF    = 2;
   localparam int DATA_WIDTH_DEF = 64;

   localparam logic OP_DEPOSIT = 1'b0;
   localparam logic OP_TAKE    = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_D_NEXT,
      S_D_WRITE,
      S_D_LINK,
      S_T_HEAD,
      S_T_LOOK,
      S_T_CHECK,
      S_T_UNLINK,
      S_T_PUSH
   } state_type;

   typedef struct packed {
      logic       init_step;
      logic       latch;
      logic       link_rd_free;
      logic       link_rd_newest;
      logic       cap_next;
      logic       dep_write;
      logic       dep_commit;
      logic       cap_cur;
      logic       walk_eval;
      logic       unlink;
      logic       push;
      logic       respond;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic is_take;
      logic dep_ok;
      logic take_ok;
      logic class_match;
      logic walk_last;
   } stat_type;

endpackage

[hdl/tsbq_ctrl.sv]
// ----------------------------------------------------------------------------
// tsbq_ctrl
// sequencer for link init, deposit and take walk of the shared buffer queue
// ----------------------------------------------------------------------------
module tsbq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tsbq_pkg::stat_type stat,
   output logic               busy,
   output tsbq_pkg::cmd_type  cmd
);
   import tsbq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_take) begin
               state_in = stat.take_ok ? S_T_HEAD : S_IDLE;
            end else begin
               state_in = stat.dep_ok ? S_D_NEXT : S_IDLE;
            end
         end
         S_D_NEXT:   state_in = S_D_WRITE;
         S_D_WRITE:  state_in = S_D_LINK;
         S_D_LINK:   state_in = S_IDLE;
         S_T_HEAD:   state_in = S_T_LOOK;
         S_T_LOOK:   state_in = S_T_CHECK;
         S_T_CHECK: begin
            if (stat.class_match) begin
               state_in = S_T_UNLINK;
            end else if (stat.walk_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_T_LOOK;
            end
         end
         S_T_UNLINK: state_in = S_T_PUSH;
         S_T_PUSH:   state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.code = ST_DONE;
      case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
         end
         S_IDLE: begin
            cmd.latch = start;
         end
         S_CHECK: begin
            if (stat.is_take) begin
               cmd.link_rd_newest = stat.take_ok;
               cmd.respond        = !stat.take_ok;
               cmd.code           = ST_EMPTY;
            end else begin
               cmd.link_rd_free = stat.dep_ok;
               cmd.respond      = !stat.dep_ok;
               cmd.code         = ST_FULL;
            end
         end
         S_D_NEXT: begin
            cmd.cap_next       = 1'b1;
            cmd.link_rd_newest = 1'b1;
         end
         S_D_WRITE: begin
            cmd.dep_write = 1'b1;
         end
         S_D_LINK: begin
            cmd.dep_commit = 1'b1;
            cmd.respond    = 1'b1;
         end
         S_T_HEAD: begin
            cmd.cap_cur = 1'b1;
         end
         S_T_CHECK: begin
            cmd.walk_eval = 1'b1;
            cmd.respond   = !stat.class_match && stat.walk_last;
            cmd.code      = ST_EMPTY;
         end
         S_T_UNLINK: begin
            cmd.unlink = 1'b1;
         end
         S_T_PUSH: begin
            cmd.push    = 1'b1;
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[hdl/tsbq_dp.sv]
// ----------------------------------------------------------------------------
// tsbq_dp
// slot memories, list pointers, counters and result registers
// ----------------------------------------------------------------------------
module tsbq_dp #(
   parameter int DEPTH      = tsbq_pkg::DEPTH_DEF,
   parameter int CLASSES    = tsbq_pkg::CLASSES_DEF,
   parameter int DATA_WIDTH = tsbq_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tsbq_pkg::cmd_type            cmd,
   output tsbq_pkg::stat_type           stat,
   input  logic                         req_opcode,
   input  logic [$clog2(CLASSES)-1:0]   req_msg_class,
   input  logic [DATA_WIDTH-1:0]        req_payload,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [DATA_WIDTH-1:0]        rsp_payload_out,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_free_slots
);
   import tsbq_pkg::*;

   localparam int SW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CLW = $clog2(CLASSES);

   logic [DATA_WIDTH-1:0] pay_mem [DEPTH];
   logic [CLW-1:0]        cls_mem [DEPTH];
   logic [SW-1:0]         link_mem [DEPTH];

   logic [DATA_WIDTH-1:0] pay_rd_ff;
   logic [CLW-1:0]        cls_rd_ff;
   logic [SW-1:0]         link_rd_ff;

   logic                  op_ff;
   logic [CLW-1:0]        cls_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [SW-1:0]         slot_ff;
   logic [SW-1:0]         prev_ff;
   logic [SW-1:0]         next_ff;
   logic [SW-1:0]         step_ff;
   logic [SW-1:0]         init_ff;
   logic [SW-1:0]         free_head_ff;
   logic [SW-1:0]         newest_ff;
   logic                  empty_ff;
   logic [CW-1:0]         free_count_ff;
   logic [CW-1:0]         free_count_in;
   logic [CW-1:0]         class_count_ff [CLASSES];

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_payload_ff;
   logic [CW-1:0]         rsp_free_ff;

   logic                  link_we;
   logic [SW-1:0]         link_addr;
   logic [SW-1:0]         link_wdata;
   logic                  cls_valid;
   logic                  match;

   // link port select
   always_comb begin
      link_we    = 1'b0;
      link_addr  = slot_ff;
      link_wdata = slot_ff;
      if (cmd.init_step) begin
         link_we    = 1'b1;
         link_addr  = init_ff;
         link_wdata = (init_ff == '0) ? '0 : init_ff - SW'(1);
      end else if (cmd.link_rd_free) begin
         link_addr = free_head_ff;
      end else if (cmd.link_rd_newest) begin
         link_addr = newest_ff;
      end else if (cmd.dep_write) begin
         link_we    = 1'b1;
         link_wdata = empty_ff ? slot_ff : link_rd_ff;
      end else if (cmd.dep_commit) begin
         link_we    = !empty_ff;
         link_addr  = newest_ff;
         link_wdata = slot_ff;
      end else if (cmd.unlink) begin
         link_we    = 1'b1;
         link_addr  = prev_ff;
         link_wdata = next_ff;
      end else if (cmd.push) begin
         link_we    = 1'b1;
         link_wdata = free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_addr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.dep_write) begin
         pay_mem[slot_ff] <= data_ff;
         cls_mem[slot_ff] <= cls_ff;
      end
      pay_rd_ff <= pay_mem[slot_ff];
      cls_rd_ff <= cls_mem[slot_ff];
   end

   assign cls_valid = (int'(cls_ff) < CLASSES);
   assign match     = (cls_rd_ff == cls_ff);

   always_comb begin
      stat.init_last   = (init_ff == SW'(DEPTH - 1));
      stat.is_take     = (op_ff == OP_TAKE);
      stat.dep_ok      = cls_valid && (free_count_ff != '0);
      stat.take_ok     = cls_valid && !empty_ff && (class_count_ff[cls_ff] != '0);
      stat.class_match = match;
      stat.walk_last   = (step_ff == SW'(DEPTH - 1));
   end

   always_comb begin
      free_count_in = free_count_ff;
      if (cmd.dep_commit) begin
         free_count_in = free_count_ff - CW'(1);
      end else if (cmd.push) begin
         free_count_in = free_count_ff + CW'(1);
      end
   end

   // request and walk registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_opcode;
         cls_ff  <= req_msg_class;
         data_ff <= req_payload;
         slot_ff <= free_head_ff;
         prev_ff <= newest_ff;
      end
      if (cmd.cap_next) begin
         next_ff <= link_rd_ff;
      end
      if (cmd.cap_cur) begin
         slot_ff <= link_rd_ff;
         step_ff <= '0;
      end
      if (cmd.walk_eval) begin
         next_ff <= link_rd_ff;
         if (!match) begin
            prev_ff <= slot_ff;
            slot_ff <= link_rd_ff;
            step_ff <= step_ff + SW'(1);
         end
      end
   end

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff       <= '0;
         free_head_ff  <= SW'(DEPTH - 1);
         newest_ff     <= '0;
         empty_ff      <= 1'b1;
         free_count_ff <= CW'(DEPTH);
         for (int c = 0; c < CLASSES; c++) begin
            class_count_ff[c] <= '0;
         end
      end else begin
         if (cmd.init_step) begin
            init_ff <= init_ff + SW'(1);
         end
         free_count_ff <= free_count_in;
         if (cmd.dep_commit) begin
            free_head_ff <= next_ff;
            newest_ff    <= slot_ff;
            empty_ff     <= 1'b0;
         end
         if (cmd.unlink && (slot_ff == newest_ff)) begin
            if (next_ff == slot_ff) begin
               empty_ff <= 1'b1;
            end else begin
               newest_ff <= prev_ff;
            end
         end
         if (cmd.push) begin
            free_head_ff <= slot_ff;
         end
         for (int c = 0; c < CLASSES; c++) begin
            if (cls_ff == CLW'(c)) begin
               if (cmd.dep_commit) begin
                  class_count_ff[c] <= class_count_ff[c] + CW'(1);
               end else if (cmd.push) begin
                  class_count_ff[c] <= class_count_ff[c] - CW'(1);
               end
            end
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff  <= cmd.code;
         rsp_payload_ff <= (cmd.push) ? pay_rd_ff : '0;
         rsp_free_ff    <= free_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_free_slots  = rsp_free_ff;

endmodule

[hdl/typed_shared_buffer_queue.sv]
// ----------------------------------------------------------------------------
// typed_shared_buffer_queue
// pool of message slots shared by several classes, free list plus age list
// ----------------------------------------------------------------------------
// After reset the block chains the link memory into the free list in
// S_INIT and holds busy high meanwhile. A request is taken when start is
// high and busy is low. A deposit runs S_CHECK, S_D_NEXT, S_D_WRITE and
// S_D_LINK, a rejected request ends in S_CHECK, and its result strobes on
// rsp_valid right after. A take walks the age list from the oldest entry
// through the single-port link memory, in S_T_LOOK and S_T_CHECK for each
// entry, up to the first of the class (position 1 to DEPTH). Each result
// is shown for one cycle only; the receiver cannot stall it.
module typed_shared_buffer_queue #(
   parameter int DEPTH      = tsbq_pkg::DEPTH_DEF,
   parameter int CLASSES    = tsbq_pkg::CLASSES_DEF,
   parameter int DATA_WIDTH = tsbq_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [$clog2(CLASSES)-1:0]   req_msg_class,
   input  logic [DATA_WIDTH-1:0]        req_payload,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [DATA_WIDTH-1:0]        rsp_payload_out,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_free_slots
);
   import tsbq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tsbq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   tsbq_dp #(
      .DEPTH      (DEPTH),
      .CLASSES    (CLASSES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_msg_class   (req_msg_class),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_payload_out (rsp_payload_out),
      .rsp_free_slots  (rsp_free_slots)
   );

endmodule
